### hw/rtl/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel core.
// No dependencies; every other file in hw/rtl imports this package.
package mbe_pkg;

  localparam int COORD_W = 32;   // Q5.26 coordinate
  localparam int FRAC_W  = 26;
  localparam int STEP_W  = 31;
  localparam int DIM_W   = 12;   // col/row index
  localparam int SIZE_W  = 13;   // frame_width/frame_height
  localparam int ITER_W  = 16;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int SQ_W    = 2 * (FRAC_W + 1);  // |z| < 2 -> square below 2^54
  localparam int SAT_W   = 45;                // widest pre-saturation sum
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd5;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_CX,     // multiply col*step
    S_CY,     // form cx, multiply row*step
    S_CINIT,  // form cy, clear z
    S_CHK,    // limit and magnitude test, multiply zx*zx
    S_YY,     // multiply zy*zy
    S_XY,     // escape sum and difference, multiply zx*zy
    S_UPD     // new z
  } mbe_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [STEP_W-1:0]  pixel_step;
    logic [ITER_W-1:0]  max_iter;
  } mbe_cfg_t;

  typedef struct packed {
    logic start;
    logic ack;
  } mbe_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } mbe_sts_t;

  // Clamp a signed SAT_W-bit value to the signed COORD_W range.
  function automatic logic [COORD_W-1:0] sat_coord(input logic [SAT_W-1:0] v);
    logic ovf;
    ovf = (v[SAT_W-1:COORD_W-1] != {(SAT_W-COORD_W+1){v[SAT_W-1]}});
    if (!ovf) return v[COORD_W-1:0];
    return v[SAT_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  // |z| >= 2 in Q.26: at or above 2^27 or at or below -2^27.
  function automatic logic is_large(input logic [COORD_W-1:0] z);
    logic big_pos, small_neg;
    big_pos   = !z[COORD_W-1] && (z[COORD_W-2:FRAC_W+1] != '0);
    small_neg = z[COORD_W-1] && (z[COORD_W-2:FRAC_W+1] == '1) && (z[FRAC_W:0] != '0);
    return big_pos || (z[COORD_W-1] && !small_neg);
  endfunction

endpackage

### hw/rtl/mbe_mul.sv
// Shared signed multiplier with registered product.
// Depends on mbe_pkg.
module mbe_mul import mbe_pkg::*; (
  input  logic               clk,
  input  logic [COORD_W-1:0] a,
  input  logic [COORD_W-1:0] b,
  output logic [PROD_W-1:0]  p
);

  always_ff @(posedge clk) begin
    p <= PROD_W'($signed(a) * $signed(b));
  end

endmodule

### hw/rtl/mbe_engine.sv
// Escape-time sequencer: forms c, then iterates z = z*z + c through one
// shared multiplier. Depends on mbe_pkg and mbe_mul.
module mbe_engine import mbe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mbe_ctl_t          ctl,
  input  mbe_cfg_t          cfg,
  input  logic [DIM_W-1:0]  col,
  input  logic [DIM_W-1:0]  row,
  output mbe_sts_t          sts,
  output logic [ITER_W-1:0] iterations
);

  mbe_state_t state, state_next;

  logic [DIM_W-1:0]   col_q, row_q;
  logic [COORD_W-1:0] cx, cy, zx, zy;
  logic [SQ_W-1:0]    xx;
  logic [SQ_W:0]      diff;        // xx - yy, signed
  logic               esc;
  logic [ITER_W-1:0]  n;

  logic [COORD_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0]  p;

  logic [SAT_W-1:0]   c_sum, nx_sum, ny_sum;
  logic [SQ_W:0]      sq_sum;
  logic [SQ_W-FRAC_W:0]   diff_sh;  // floor(diff / 2^26)
  logic [SQ_W-FRAC_W+1:0] xy_sh;    // floor(2*xy / 2^26)
  logic               stop;

  mbe_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  // c component: origin plus unsigned index*step product
  assign c_sum = (state == S_CY)
      ? {{(SAT_W-COORD_W){cfg.origin_x[COORD_W-1]}}, cfg.origin_x}
        + {{(SAT_W-DIM_W-STEP_W){1'b0}}, p[DIM_W+STEP_W-1:0]}
      : {{(SAT_W-COORD_W){cfg.origin_y[COORD_W-1]}}, cfg.origin_y}
        + {{(SAT_W-DIM_W-STEP_W){1'b0}}, p[DIM_W+STEP_W-1:0]};

  assign sq_sum  = {1'b0, xx} + {1'b0, p[SQ_W-1:0]};
  assign diff_sh = diff[SQ_W:FRAC_W];
  assign xy_sh   = p[SQ_W:FRAC_W-1];
  assign nx_sum  = {{(SAT_W-SQ_W+FRAC_W-1){diff_sh[SQ_W-FRAC_W]}}, diff_sh}
                 + {{(SAT_W-COORD_W){cx[COORD_W-1]}}, cx};
  assign ny_sum  = {{(SAT_W-SQ_W+FRAC_W-2){xy_sh[SQ_W-FRAC_W+1]}}, xy_sh}
                 + {{(SAT_W-COORD_W){cy[COORD_W-1]}}, cy};
  assign stop    = (n >= cfg.max_iter) || is_large(zx) || is_large(zy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sts.idle   = 1'b0;
    sts.done   = 1'b0;
    mul_a      = zx;
    mul_b      = zy;
    unique case (state)
      S_IDLE: begin
        sts.idle = 1'b1;
        if (ctl.start) state_next = S_CX;
      end
      S_CX: begin
        mul_a      = {{(COORD_W-DIM_W){1'b0}}, col_q};
        mul_b      = {{(COORD_W-STEP_W){1'b0}}, cfg.pixel_step};
        state_next = S_CY;
      end
      S_CY: begin
        mul_a      = {{(COORD_W-DIM_W){1'b0}}, row_q};
        mul_b      = {{(COORD_W-STEP_W){1'b0}}, cfg.pixel_step};
        state_next = S_CINIT;
      end
      S_CINIT: state_next = S_CHK;
      S_CHK: begin
        mul_a = zx;
        mul_b = zx;
        if (stop) begin
          sts.done = 1'b1;
          if (ctl.ack) state_next = S_IDLE;
        end else begin
          state_next = S_YY;
        end
      end
      S_YY: begin
        mul_a      = zy;
        mul_b      = zy;
        state_next = S_XY;
      end
      S_XY: state_next = S_UPD;   // zx*zy
      S_UPD: begin
        // escaped points wait in S_CHK with stop forced by the magnitude test
        state_next = S_CHK;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // An escape in S_UPD forces zx to COORD_MAX and pins n so that S_CHK reports done.
  always_ff @(posedge clk) begin
    if (ctl.start && state == S_IDLE) begin
      col_q <= col;
      row_q <= row;
    end
    unique case (state)
      S_CY:    cx <= sat_coord(c_sum);
      S_CINIT: begin
        cy <= sat_coord(c_sum);
        zx <= '0;
        zy <= '0;
        n  <= '0;
        esc <= 1'b0;
      end
      S_YY:    xx <= p[SQ_W-1:0];
      S_XY: begin
        esc  <= sq_sum[SQ_W];
        diff <= {1'b0, xx} - {1'b0, p[SQ_W-1:0]};
      end
      S_UPD: begin
        if (!esc) begin
          zx <= sat_coord(nx_sum);
          zy <= sat_coord(ny_sum);
          n  <= n + ITER_W'(1);
        end else begin
          // force the stop test: escaped with n unchanged
          zx <= COORD_MAX;
        end
      end
      default: ;
    endcase
  end

  assign iterations = n;

endmodule

### hw/rtl/mandelbrot_escape_pixel_core.sv
// Top level of the Mandelbrot escape-time pixel core: configuration
// registers, stream handshakes, result register. Depends on mbe_pkg, mbe_engine.
//
//  channel  | dir | handshake                | payload
//  ---------+-----+--------------------------+-------------------------------
//  s_*      | in  | s_tvalid / s_tready      | s_tdata = {row, col}
//  m_*      | out | m_tvalid / m_tready      | m_tdata = iterations, m_tlast = frame_end
//  cfg_*    | in  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Per pixel the sequencer forms c in S_CX, S_CY and S_CINIT, then runs S_CHK, S_YY,
// S_XY and S_UPD once per iteration done, plus one more pass when the point escapes
// on the sum of squares (that pass runs all three products but counts nothing); each
// iteration is three passes through the single shared multiplier plus an update.
// Input ready only while the sequencer is idle.
// Reset (rst, sync, high) restores the register defaults and idles the core.
// A result waiting on m_tready does not block the next pixel from being taken;
// the sequencer holds its finished count until the result register frees.
module mandelbrot_escape_pixel_core import mbe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,    // [11:0] col, [23:12] row
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [ITER_W-1:0]     m_tdata,    // [15:0] iterations
  output logic                  m_tlast,    // frame_end
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  mbe_cfg_t          cfg;
  logic [SIZE_W-1:0] frame_width, frame_height;
  mbe_ctl_t          ctl;
  mbe_sts_t          sts;
  logic [ITER_W-1:0] eng_iter;
  logic              last_pend;
  logic              out_load;
  logic [DIM_W-1:0]  in_col, in_row;

  assign in_col    = s_tdata[DIM_W-1:0];
  assign in_row    = s_tdata[2*DIM_W-1:DIM_W];
  assign cfg_ready = 1'b1;

  // Config registers; writes outside the map are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x   <= '0;
      cfg.origin_y   <= '0;
      cfg.pixel_step <= STEP_W'(67108);
      frame_width    <= SIZE_W'(1000);
      frame_height   <= SIZE_W'(1000);
      cfg.max_iter   <= ITER_W'(255);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ORIGIN_X:     cfg.origin_x   <= cfg_data[COORD_W-1:0];
        REG_ORIGIN_Y:     cfg.origin_y   <= cfg_data[COORD_W-1:0];
        REG_PIXEL_STEP:   cfg.pixel_step <= cfg_data[STEP_W-1:0];
        REG_FRAME_WIDTH:  frame_width    <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height   <= cfg_data[SIZE_W-1:0];
        REG_MAX_ITER:     cfg.max_iter   <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready  = sts.idle;
  assign ctl.start = s_tvalid && s_tready;
  assign out_load  = sts.done && (!m_tvalid || m_tready);
  assign ctl.ack   = out_load;

  // Frame end is known at intake; col+1 can never be zero, so a zero or
  // oversized frame size simply never matches.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      last_pend <= ({1'b0, in_col} + SIZE_W'(1) == frame_width)
                && ({1'b0, in_row} + SIZE_W'(1) == frame_height);
    end
  end

  mbe_engine u_engine (
    .clk(clk), .rst(rst), .ctl(ctl), .cfg(cfg),
    .col(in_col), .row(in_row), .sts(sts), .iterations(eng_iter)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= eng_iter;
      m_tlast <= last_pend;
    end
  end

`ifndef NO_ASSERTIONS
  // Taking a pixel starts the sequencer, so intake closes the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after a pixel was taken");

  // Idle and done are exclusive sequencer conditions.
  a_idle_not_done: assert property (@(posedge clk) disable iff (rst)
    !(sts.idle && sts.done))
    else $error("sequencer idle and done at once");

  // A new result only appears after the sequencer offered one.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid ##1 m_tvalid) |-> $past(sts.done))
    else $error("result appeared without a finished pixel");
`endif

endmodule
